>>> rtl/cpt_pkg.sv
// ----------------------------------------------------------------------------
// Cherry polynomial table package
// Action, status and kind codes, and the control bundle for the row unit.
// ----------------------------------------------------------------------------
package cpt_pkg;

   localparam logic [2:0] ACT_START      = 3'd0;
   localparam logic [2:0] ACT_START_RET  = 3'd1;
   localparam logic [2:0] ACT_ADD        = 3'd2;
   localparam logic [2:0] ACT_ADD_RET    = 3'd3;
   localparam logic [2:0] ACT_REDUCE     = 3'd4;
   localparam logic [2:0] ACT_REDUCE_RET = 3'd5;
   localparam logic [2:0] ACT_FIND_MIN   = 3'd6;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_FULL      = 2'd1;
   localparam logic [1:0] ST_EMPTY     = 2'd2;
   localparam logic [1:0] ST_BAD_INDEX = 2'd3;

   localparam logic [1:0] KIND_NONE = 2'd0;
   localparam logic [1:0] KIND_PLAIN = 2'd1;
   localparam logic [1:0] KIND_RET  = 2'd2;

   localparam logic [3:0] LEAF_NONE = 4'hF;

   // Operation and leaf pair presented to the shared row unit.
   typedef struct packed {
      logic [2:0] op;
      logic [3:0] leaf_x;
      logic [3:0] leaf_y;
   } row_ctrl_type;

endpackage

>>> rtl/cpt_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cpt_ram #(
   parameter int WIDTH = 256,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

>>> rtl/cpt_row_unit.sv
// ----------------------------------------------------------------------------
// Row unit
// Rewrites one monomial for add and reduce, and tests it for cherry shape.
// ----------------------------------------------------------------------------
module cpt_row_unit #(
   parameter int LEAF_COUNT = 15,
   parameter int EXP_WIDTH  = 16
) (
   input  cpt_pkg::row_ctrl_type                     ctrl,
   input  logic [(LEAF_COUNT+1)*EXP_WIDTH-1:0]       row_in,
   input  logic [(LEAF_COUNT+1)*EXP_WIDTH-1:0]       ref_row,
   output logic [(LEAF_COUNT+1)*EXP_WIDTH-1:0]       row_out,
   output logic                                      hit,
   output logic [1:0]                                hit_kind,
   output logic [$clog2(LEAF_COUNT+1)-1:0]           hit_a,
   output logic [$clog2(LEAF_COUNT+1)-1:0]           hit_b
);

   localparam int EW = EXP_WIDTH;
   localparam int LW = $clog2(LEAF_COUNT + 1);
   localparam logic [EW-1:0] EXP_MAX = {EW{1'b1}};

   logic [EW-1:0]   e0, ex, ey, rx, ry;
   logic [EW+1:0]   sum3, sum2;
   logic [EW-1:0]   new0, newx;
   logic            ok, have_a, have_b;
   logic [LW-1:0]   a, b;
   logic [EW-1:0]   lane;

   // Column selection and the saturating or flooring arithmetic.
   always_comb begin
      e0 = row_in[EW-1:0];
      ex = '0;
      ey = '0;
      for (int i = 1; i <= LEAF_COUNT; i++) begin
         if (32'(ctrl.leaf_x) == i) begin
            ex = row_in[i*EW +: EW];
         end
         if (32'(ctrl.leaf_y) == i) begin
            ey = row_in[i*EW +: EW];
         end
      end
      sum3 = {2'b00, e0} + {2'b00, ex} + {2'b00, ey};
      sum2 = {2'b00, ex} + {2'b00, ey};
      new0 = e0;
      newx = ex;
      case (ctrl.op)
         cpt_pkg::ACT_ADD: begin
            newx = ey;
         end
         cpt_pkg::ACT_ADD_RET: begin
            new0 = (sum3[EW+1:EW] != 2'b00) ? EXP_MAX : sum3[EW-1:0];
            newx = (sum2[EW+1:EW] != 2'b00) ? EXP_MAX : sum2[EW-1:0];
         end
         cpt_pkg::ACT_REDUCE: begin
            newx = '0;
         end
         cpt_pkg::ACT_REDUCE_RET: begin
            new0 = (e0 > ex) ? e0 - ex : '0;
            newx = (ex > ey) ? ex - ey : '0;
         end
         default: begin
         end
      endcase
      row_out = row_in;
      row_out[EW-1:0] = new0;
      for (int i = 1; i <= LEAF_COUNT; i++) begin
         if (32'(ctrl.leaf_x) == i) begin
            row_out[i*EW +: EW] = newx;
         end
      end
   end

   // Cherry shape test: exactly two leaf exponents equal to one, all others
   // zero, and a reticulation exponent of zero or one.
   always_comb begin
      ok     = (row_in[EW-1:0] <= EW'(1));
      have_a = 1'b0;
      have_b = 1'b0;
      a      = '0;
      b      = '0;
      lane   = '0;
      for (int i = 1; i <= LEAF_COUNT; i++) begin
         lane = row_in[i*EW +: EW];
         if (lane > EW'(1)) begin
            ok = 1'b0;
         end else if (lane == EW'(1)) begin
            if (!have_a) begin
               have_a = 1'b1;
               a      = LW'(i);
            end else if (!have_b) begin
               have_b = 1'b1;
               b      = LW'(i);
            end else begin
               ok = 1'b0;
            end
         end
      end
      rx = '0;
      ry = '0;
      for (int i = 1; i <= LEAF_COUNT; i++) begin
         if (LW'(i) == a) begin
            rx = ref_row[i*EW +: EW];
         end
         if (LW'(i) == b) begin
            ry = ref_row[i*EW +: EW];
         end
      end
      hit      = ok && have_b;
      hit_kind = (row_in[EW-1:0] == EW'(1)) ? cpt_pkg::KIND_RET : cpt_pkg::KIND_PLAIN;
      hit_a    = (rx < ry) ? b : a;
      hit_b    = (rx < ry) ? a : b;
   end

endmodule

>>> rtl/cherry_polynomial_table_engine.sv
// ----------------------------------------------------------------------------
// Cherry polynomial table engine
// Stack of exponent rows rewritten and scanned one row at a time.
// ----------------------------------------------------------------------------
// Sequencing: start, bad index and empty or full cases go from accept straight
// to the finish state; add and reduce walk the rows in turn, and add then pushes
// a new row; find-min walks every row. Each row takes a RAM read state and a work state.
// Throughput: one item at a time; the next item is taken once the sequencer
// is idle, even while the previous result still waits on rsp_tready.
// Reset clears the stack count, the state, the found flag and the result valid; the RAM is not cleared.
// ----------------------------------------------------------------------------
module cherry_polynomial_table_engine #(
   parameter int LEAF_COUNT  = 15,
   parameter int STACK_DEPTH = 64,
   parameter int EXP_WIDTH   = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // leaf_x[3:0], leaf_y[7:4]
   input  logic [2:0]  req_tuser,   // action[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // status[1:0], cherry_kind[3:2],
                                    // min_first[7:4], min_second[11:8], zeros
);

   localparam int EW = EXP_WIDTH;
   localparam int RW = (LEAF_COUNT + 1) * EXP_WIDTH;
   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int LW = $clog2(LEAF_COUNT + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_WORK,
      S_PUSH,
      S_FINISH
   } state_type;

   state_type     state_ff, state_in;
   logic [2:0]    act_ff, act_in;
   logic [3:0]    x_ff, x_in, y_ff, y_in;
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [RW-1:0] ref_ff, ref_in;
   logic [1:0]    status_ff, status_in;
   logic          found_ff, found_in;
   logic [LW-1:0] best_a_ff, best_a_in, best_b_ff, best_b_in;
   logic [1:0]    best_k_ff, best_k_in;
   logic          rsp_tvalid_ff, rsp_tvalid_in;
   logic [15:0]   rsp_tdata_ff, rsp_tdata_in;

   logic          wr_en, rd_en;
   logic [AW-1:0] wr_addr;
   logic [RW-1:0] wr_data, rd_data, row_new, cherry_row;
   logic          hit;
   logic [1:0]    hit_kind;
   logic [LW-1:0] hit_a, hit_b;
   logic          accept, x_ok, y_ok, last_row;
   logic [2:0]    a_act;
   logic [3:0]    a_x, a_y;
   cpt_pkg::row_ctrl_type ctrl;

   assign accept = req_tvalid && req_tready;
   assign a_act  = req_tuser;
   assign a_x    = req_tdata[3:0];
   assign a_y    = req_tdata[7:4];
   assign x_ok   = (a_x != 4'd0) && (32'(a_x) <= LEAF_COUNT);
   assign y_ok   = (a_y != 4'd0) && (32'(a_y) <= LEAF_COUNT);

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   assign ctrl.op     = act_ff;
   assign ctrl.leaf_x = x_ff;
   assign ctrl.leaf_y = y_ff;

   assign last_row = (CW'(idx_ff) + CW'(1) == count_ff);

   // The new top row for start and push: ones at x and y, slot 0 marks a
   // reticulated cherry. Start takes its leaves from the bus, push from the
   // latched item.
   always_comb begin
      logic [3:0] cx, cy;
      logic       cret;
      cx   = (state_ff == S_IDLE) ? a_x : x_ff;
      cy   = (state_ff == S_IDLE) ? a_y : y_ff;
      cret = (state_ff == S_IDLE) ? (a_act == cpt_pkg::ACT_START_RET)
                                  : (act_ff == cpt_pkg::ACT_ADD_RET);
      cherry_row = '0;
      cherry_row[EW-1:0] = cret ? EW'(1) : '0;
      for (int i = 1; i <= LEAF_COUNT; i++) begin
         if (32'(cx) == i || 32'(cy) == i) begin
            cherry_row[i*EW +: EW] = EW'(1);
         end
      end
   end

   cpt_ram #(
      .WIDTH (RW),
      .DEPTH (STACK_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   cpt_row_unit #(
      .LEAF_COUNT (LEAF_COUNT),
      .EXP_WIDTH  (EXP_WIDTH)
   ) u_row (
      .ctrl     (ctrl),
      .row_in   (rd_data),
      .ref_row  (ref_ff),
      .row_out  (row_new),
      .hit      (hit),
      .hit_kind (hit_kind),
      .hit_a    (hit_a),
      .hit_b    (hit_b)
   );

   // Sequencer. Add and reduce read each row, rewrite it in the next cycle,
   // then move on; find-min walks from the top row down so that on a tie the
   // higher row keeps the kind. Row 0 is mirrored in ref_ff for the ordering.
   always_comb begin
      state_in      = state_ff;
      act_in        = act_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      ref_in        = ref_ff;
      status_in     = status_ff;
      found_in      = found_ff;
      best_a_in     = best_a_ff;
      best_b_in     = best_b_ff;
      best_k_in     = best_k_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = row_new;
      rd_en         = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               act_in    = a_act;
               x_in      = a_x;
               y_in      = a_y;
               status_in = cpt_pkg::ST_OK;
               found_in  = 1'b0;
               idx_in    = '0;
               state_in  = S_FINISH;
               case (a_act)
                  cpt_pkg::ACT_START, cpt_pkg::ACT_START_RET: begin
                     if (!x_ok || !y_ok) begin
                        status_in = cpt_pkg::ST_BAD_INDEX;
                     end else begin
                        wr_en    = 1'b1;
                        wr_data  = cherry_row;
                        ref_in   = cherry_row;
                        count_in = CW'(1);
                     end
                  end
                  cpt_pkg::ACT_ADD, cpt_pkg::ACT_ADD_RET: begin
                     if (!x_ok || !y_ok) begin
                        status_in = cpt_pkg::ST_BAD_INDEX;
                     end else if (count_ff == '0) begin
                        status_in = cpt_pkg::ST_EMPTY;
                     end else if (32'(count_ff) >= STACK_DEPTH) begin
                        status_in = cpt_pkg::ST_FULL;
                     end else begin
                        state_in = S_READ;
                     end
                  end
                  cpt_pkg::ACT_REDUCE, cpt_pkg::ACT_REDUCE_RET: begin
                     if (!x_ok || (a_act == cpt_pkg::ACT_REDUCE_RET && !y_ok)) begin
                        status_in = cpt_pkg::ST_BAD_INDEX;
                     end else if (count_ff == '0) begin
                        status_in = cpt_pkg::ST_EMPTY;
                     end else begin
                        count_in = count_ff - CW'(1);
                        if (count_ff != CW'(1)) begin
                           state_in = S_READ;
                        end
                     end
                  end
                  cpt_pkg::ACT_FIND_MIN: begin
                     if (count_ff == '0) begin
                        status_in = cpt_pkg::ST_EMPTY;
                     end else begin
                        idx_in   = AW'(count_ff - CW'(1));
                        state_in = S_READ;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_READ: begin
            rd_en    = 1'b1;
            state_in = S_WORK;
         end
         S_WORK: begin
            if (act_ff == cpt_pkg::ACT_FIND_MIN) begin
               if (hit && (!found_ff || hit_a < best_a_ff ||
                           (hit_a == best_a_ff && hit_b < best_b_ff))) begin
                  found_in  = 1'b1;
                  best_a_in = hit_a;
                  best_b_in = hit_b;
                  best_k_in = hit_kind;
               end
               if (idx_ff == '0) begin
                  state_in = S_FINISH;
               end else begin
                  idx_in   = idx_ff - AW'(1);
                  state_in = S_READ;
               end
            end else begin
               wr_en   = 1'b1;
               wr_addr = idx_ff;
               if (idx_ff == '0) begin
                  ref_in = row_new;
               end
               if (last_row) begin
                  state_in = (act_ff == cpt_pkg::ACT_ADD ||
                              act_ff == cpt_pkg::ACT_ADD_RET) ? S_PUSH : S_FINISH;
               end else begin
                  idx_in   = idx_ff + AW'(1);
                  state_in = S_READ;
               end
            end
         end
         S_PUSH: begin
            wr_en    = 1'b1;
            wr_addr  = AW'(count_ff);
            wr_data  = cherry_row;
            count_in = count_ff + CW'(1);
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {4'd0, cpt_pkg::LEAF_NONE, cpt_pkg::LEAF_NONE,
                                cpt_pkg::KIND_NONE, status_ff};
               if (act_ff == cpt_pkg::ACT_FIND_MIN && found_ff) begin
                  rsp_tdata_in = {4'd0, 4'(best_b_ff), 4'(best_a_ff), best_k_ff, status_ff};
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
         found_ff      <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         found_ff      <= found_in;
      end
      act_ff       <= act_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      idx_ff       <= idx_in;
      ref_ff       <= ref_in;
      status_ff    <= status_in;
      best_a_ff    <= best_a_in;
      best_b_ff    <= best_b_in;
      best_k_ff    <= best_k_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= STACK_DEPTH)
      else $error("stack count beyond depth");

   a_write_in_stack: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (CW'(wr_addr) <= count_ff))
      else $error("row write above the stack top");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> $past(state_ff == S_FINISH))
      else $error("result raised outside finish");

   a_busy_no_rsp_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |=> (state_ff == S_WORK))
      else $error("read not followed by work cycle");

endmodule
